>>> src/rpn_pkg.sv
// rpn_pkg: shared types, codes and arithmetic helpers for the RPN stack calculator.
// Depends on nothing; used by rpn_alu, rpn_stack_calculator and rpn_checker.
package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int OPC_W           = 3;
  localparam int STAT_W          = 2;
  localparam int CNT_OUT_W       = 5;
  localparam int MAG_W           = 48;
  localparam int MUL_STEPS       = 32;
  localparam int DIV_STEPS       = 48;
  localparam int STEP_W          = 6;
  localparam int FRAC_W          = 16;

  localparam logic [OPC_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OPC_W-1:0] OP_ADD   = 3'd1;
  localparam logic [OPC_W-1:0] OP_SUB   = 3'd2;
  localparam logic [OPC_W-1:0] OP_MUL   = 3'd3;
  localparam logic [OPC_W-1:0] OP_DIV   = 3'd4;
  localparam logic [OPC_W-1:0] OP_CLEAR = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_DIVZERO = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  localparam logic [DATA_W-1:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MIN_NEG = 32'h8000_0000;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] v);
    magnitude = v[DATA_W-1] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [DATA_W-1:0] sat_mag(input logic neg, input logic [MAG_W-1:0] mag);
    logic [DATA_W-1:0] res;
    if (neg) begin
      if (mag >= {16'd0, MIN_NEG}) res = MIN_NEG;
      else res = ~mag[DATA_W-1:0] + 32'd1;
    end else begin
      if (mag > {16'd0, MAX_POS}) res = MAX_POS;
      else res = mag[DATA_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] sat_addsub(input logic [DATA_W-1:0] a,
                                                   input logic [DATA_W-1:0] b,
                                                   input logic sub);
    logic [DATA_W:0] s;
    logic [DATA_W-1:0] res;
    if (sub) s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
    else s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) res = s[DATA_W] ? MIN_NEG : MAX_POS;
    else res = s[DATA_W-1:0];
    return res;
  endfunction

endpackage

>>> src/rpn_alu.sv
// rpn_alu: shared Q16.16 arithmetic unit; add and subtract registered straight from idle,
// shift-add multiply and restoring divide one bit per cycle, all saturating.
// Depends on rpn_pkg.
module rpn_alu (
  input  logic                      clk,
  input  logic                      rst,
  input  rpn_pkg::alu_req_t         req,
  input  logic [rpn_pkg::DATA_W-1:0] lhs,
  input  logic [rpn_pkg::DATA_W-1:0] rhs,
  output logic                      done,
  output logic [rpn_pkg::DATA_W-1:0] result
);
  import rpn_pkg::*;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_FIN  = 4'b1000
  } alu_state_t;

  alu_state_t        state;
  logic [STEP_W-1:0] step;
  logic              neg;
  logic              is_mul;
  logic [DATA_W-1:0] mcand;
  logic [2*DATA_W-1:0] acc;
  logic [DATA_W-1:0] dvsr;
  logic [DATA_W-1:0] rem;
  logic [MAG_W-1:0]  quo;

  logic [DATA_W:0]   mul_sum;
  logic [DATA_W:0]   trial;
  logic              ge;

  assign mul_sum = {1'b0, acc[2*DATA_W-1:DATA_W]} + (acc[0] ? {1'b0, mcand} : '0);
  assign trial   = {rem, quo[MAG_W-1]};
  assign ge      = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.start) begin
            neg  <= lhs[DATA_W-1] ^ rhs[DATA_W-1];
            step <= '0;
            case (req.op)
              ALU_ADD: begin
                result <= sat_addsub(lhs, rhs, 1'b0);
                done   <= 1'b1;
              end
              ALU_SUB: begin
                result <= sat_addsub(lhs, rhs, 1'b1);
                done   <= 1'b1;
              end
              ALU_MUL: begin
                is_mul <= 1'b1;
                mcand  <= magnitude(lhs);
                acc    <= {{DATA_W{1'b0}}, magnitude(rhs)};
                state  <= A_MUL;
              end
              default: begin
                is_mul <= 1'b0;
                dvsr   <= magnitude(rhs);
                rem    <= '0;
                quo    <= {magnitude(lhs), {FRAC_W{1'b0}}};
                state  <= A_DIV;
              end
            endcase
          end
        end
        A_MUL: begin
          acc  <= {mul_sum, acc[DATA_W-1:1]};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(MUL_STEPS - 1)) state <= A_FIN;
        end
        A_DIV: begin
          rem  <= ge ? DATA_W'(trial - {1'b0, dvsr}) : trial[DATA_W-1:0];
          quo  <= {quo[MAG_W-2:0], ge};
          step <= step + STEP_W'(1);
          if (step == STEP_W'(DIV_STEPS - 1)) state <= A_FIN;
        end
        A_FIN: begin
          result <= sat_mag(neg, is_mul ? acc[2*DATA_W-1:FRAC_W] : quo);
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule

>>> src/rpn_stack_calculator.sv
// rpn_stack_calculator: RPN calculator on a bounded stack of Q16.16 words.
// Top of stack in a register, lower entries in a one-port-write memory.
// Depends on rpn_pkg and rpn_alu.
//
//   channel   handshake         fields
//   command   start / busy      opcode, operand_value
//   result    done (1 cycle)    top_value, status, entry_count
//
// Push, clear, unknown-opcode, refused and short-stack commands: result in the cycle after accept.
// Add and subtract: second-entry read (S_READ), ALU, then writeback in S_CALC.
// Multiply and divide take the same path, with the bit-serial ALU loop in place of the ALU step.
// Divide by zero is answered from S_READ without the ALU. busy is high after accept until the result strobe.
// Synchronous reset empties the stack; no clearing pass. Results cannot stall.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [rpn_pkg::OPC_W-1:0]          opcode,
  input  logic signed [rpn_pkg::DATA_W-1:0]  operand_value,
  output logic                               busy,
  output logic                               done,
  output logic signed [rpn_pkg::DATA_W-1:0]  top_value,
  output logic [rpn_pkg::STAT_W-1:0]         status,
  output logic [rpn_pkg::CNT_OUT_W-1:0]      entry_count
);
  import rpn_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_CALC = 3'b100
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [DATA_W-1:0] tos;
  logic [DATA_W-1:0] second;
  logic [OPC_W-1:0]  op_r;
  logic [DATA_W-1:0] mem [STACK_DEPTH];

  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;
  logic [DATA_W-1:0] cur_top;
  logic              div_zero;
  alu_req_t          alu_req;
  logic              alu_done;
  logic [DATA_W-1:0] alu_result;

  assign busy     = (state != S_IDLE);
  assign rd_addr  = AW'(count - CW'(2));
  assign wr_addr  = AW'(count - CW'(1));
  assign cur_top  = (count == '0) ? '0 : tos;
  assign wr_en    = start && !busy && (opcode == OP_PUSH) && (count != '0)
                    && (count < FULL_COUNT);
  assign div_zero = (op_r == OP_DIV) && (tos == '0);

  always_comb begin
    alu_req.start = (state == S_READ) && !div_zero;
    case (op_r)
      OP_SUB:  alu_req.op = ALU_SUB;
      OP_MUL:  alu_req.op = ALU_MUL;
      OP_DIV:  alu_req.op = ALU_DIV;
      default: alu_req.op = ALU_ADD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= tos;
    end
    second <= mem[rd_addr];
  end

  rpn_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .lhs    (second),
    .rhs    (tos),
    .done   (alu_done),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r <= opcode;
            case (opcode)
              OP_PUSH: begin
                done <= 1'b1;
                if (count >= FULL_COUNT) begin
                  top_value   <= cur_top;
                  status      <= ST_FULL;
                  entry_count <= CNT_OUT_W'(count);
                end else begin
                  tos         <= operand_value;
                  count       <= count + CW'(1);
                  top_value   <= operand_value;
                  status      <= ST_OK;
                  entry_count <= CNT_OUT_W'(count + CW'(1));
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (count == '0) begin
                  done        <= 1'b1;
                  top_value   <= '0;
                  status      <= ST_EMPTY;
                  entry_count <= '0;
                end else if (count == CW'(1)) begin
                  done        <= 1'b1;
                  top_value   <= tos;
                  status      <= ST_OK;
                  entry_count <= CNT_OUT_W'(count);
                end else begin
                  state <= S_READ;
                end
              end
              OP_CLEAR: begin
                count       <= '0;
                done        <= 1'b1;
                top_value   <= '0;
                status      <= ST_OK;
                entry_count <= '0;
              end
              default: begin
                done        <= 1'b1;
                top_value   <= cur_top;
                status      <= ST_OK;
                entry_count <= CNT_OUT_W'(count);
              end
            endcase
          end
        end
        S_READ: begin
          if (div_zero) begin
            done        <= 1'b1;
            top_value   <= tos;
            status      <= ST_DIVZERO;
            entry_count <= CNT_OUT_W'(count);
            state       <= S_IDLE;
          end else begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (alu_done) begin
            tos         <= alu_result;
            count       <= count - CW'(1);
            done        <= 1'b1;
            top_value   <= alu_result;
            status      <= ST_OK;
            entry_count <= CNT_OUT_W'(count - CW'(1));
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/rpn_checker.sv
// rpn_checker: port-level assertions for rpn_stack_calculator, with its bind.
// Depends on rpn_pkg and the top level's port list.
module rpn_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic signed [rpn_pkg::DATA_W-1:0] top_value,
  input logic [rpn_pkg::STAT_W-1:0]        status,
  input logic [rpn_pkg::CNT_OUT_W-1:0]     entry_count
);
  import rpn_pkg::*;

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word neither started nor answered");

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("busy dropped without a result");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (done && (entry_count == '0)) |-> (top_value == '0))
    else $error("empty stack reported a nonzero top");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_EMPTY)) |-> (entry_count == '0))
    else $error("empty status with entries on the stack");

  a_divzero_depth: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_DIVZERO)) |-> (entry_count >= CNT_OUT_W'(2)))
    else $error("divide by zero refused with fewer than two entries");

endmodule

bind rpn_stack_calculator rpn_checker u_rpn_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .top_value   (top_value),
  .status      (status),
  .entry_count (entry_count)
);
